/* hdl/sha256bs_pkg.sv */
// ----------------------------------------------------------------------------
// sha256bs_pkg
// Shared types, round constants and sigma functions for the byte stream
// SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256bs_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam int unsigned LINE_W      = BLOCK_BYTES * 8;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // control into the message schedule line
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       shift;
    } t_sched_ctl;

    // control into the round unit
    typedef struct packed {
        logic       load;
        logic       round;
        logic       fold;
        logic       init;
        logic [5:0] idx;
    } t_core_ctl;

    // initial chaining value H0..H7
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constants
    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // schedule sigmas
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // round sigmas
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* hdl/sha256bs_sched.sv */
// ----------------------------------------------------------------------------
// sha256bs_sched
// Block shift line: collects message bytes into one 512-bit block, then
// rolls as the sixteen-word message schedule window during the rounds.
// ----------------------------------------------------------------------------
module sha256bs_sched (
    input  logic                    i_clk,
    input  sha256bs_pkg::t_sched_ctl i_ctl,
    output logic [31:0]             o_w
);
    import sha256bs_pkg::*;

    // word k sits at bits [32k+31:32k]; oldest word (W_t) is word 15
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic [31:0]       w_new;

    // next schedule word W_t+16 from the fixed taps
    assign w_new = ssig1(r_line[63:32]) + r_line[223:192]
                 + ssig0(r_line[479:448]) + r_line[511:480];

    assign o_w = r_line[511:480];

    // byte fill or word roll
    always_comb begin
        n_line = r_line;
        if (i_ctl.push) begin
            n_line = {r_line[LINE_W-9:0], i_ctl.data};
        end else if (i_ctl.shift) begin
            n_line = {r_line[LINE_W-33:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
    end

endmodule

/* hdl/sha256bs_core.sv */
// ----------------------------------------------------------------------------
// sha256bs_core
// Round unit: holds the chaining value and the eight working variables, and
// runs one compression round per cycle.
// ----------------------------------------------------------------------------
module sha256bs_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sha256bs_pkg::t_core_ctl i_ctl,
    input  logic [31:0]             i_w,
    output logic [255:0]            o_chain
);
    import sha256bs_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    // round arithmetic
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1 = r_v[7] + bsig1(r_v[4]) + ch + K_TAB[i_ctl.idx] + i_w;
    assign t2 = bsig0(r_v[0]) + mj;

    // digest order: H0 in the top bits
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_chain[32*(7-i) +: 32] = r_h[i];
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctl.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

endmodule

/* hdl/sha256_byte_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream. Each input word carries one byte in tdata, a
// byte-present flag in tuser and an end-of-message mark in tlast. A word
// that neither fills a block nor closes the message leaves tready high. The
// word that fills a 64-byte block holds tready low through 64 rounds on the
// single round unit and the fold of the result into the chaining value. A
// word with tlast set then pads one byte per cycle, halting while a block
// compresses (9 to 72 pad bytes, one or two further compressions), and
// presents the digest as four 64-bit big-endian words, most significant
// first, with the word index in tuser and tlast on the fourth; tready stays
// low until the fourth word is taken. The bit length wraps modulo 2^64.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // end_of_message
    // digest stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] digest_word
    output logic [1:0]  o_m_tuser,   // [1:0] word_index
    output logic        o_m_tlast    // last_word
);
    import sha256bs_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic        r_closing;
    logic        r_mark_done;
    logic [3:0]  r_len_cnt;
    logic [5:0]  r_round;
    logic [1:0]  r_word_idx;

    t_sched_ctl  sched_ctl;
    t_core_ctl   core_ctl;
    logic [31:0] w_word;
    logic [255:0] chain;
    logic        in_acc;
    logic        out_acc;
    logic        block_full;
    logic        len_phase;
    logic [63:0] bitlen;
    logic [7:0]  pad_byte;

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = o_m_tvalid && i_m_tready;
    assign block_full = sched_ctl.push && (r_fill == 6'(BLOCK_BYTES - 1));
    assign bitlen     = {r_msg, 3'b000};
    assign len_phase  = (r_len_cnt != 4'd0) || (r_fill == 6'(LEN_POS));

    // padding byte: mark, zeros, then the length from the top byte down
    always_comb begin
        if (!r_mark_done) begin
            pad_byte = PAD_MARK;
        end else if (len_phase) begin
            pad_byte = bitlen[{~r_len_cnt[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (block_full) begin
                        n_state = ST_ROUND;
                    end else if (i_s_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == 6'(ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!r_closing) begin
                    n_state = ST_IDLE;
                end else if (r_len_cnt == 4'd8) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_word_idx == 2'd3)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready     = 1'b0;
        o_m_tvalid     = 1'b0;
        sched_ctl      = '0;
        core_ctl       = '0;
        core_ctl.idx   = r_round;
        case (r_state)
            ST_IDLE: begin
                o_s_tready     = 1'b1;
                sched_ctl.push = i_s_tvalid && i_s_tuser;
                sched_ctl.data = i_s_tdata;
            end
            ST_PAD: begin
                sched_ctl.push = 1'b1;
                sched_ctl.data = pad_byte;
            end
            ST_ROUND: begin
                sched_ctl.shift = 1'b1;
                core_ctl.round  = 1'b1;
            end
            ST_FOLD: begin
                core_ctl.fold = 1'b1;
            end
            ST_OUT: begin
                o_m_tvalid    = 1'b1;
                core_ctl.init = i_m_tready && (r_word_idx == 2'd3);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        core_ctl.load = block_full;
    end

    // sequencer and message bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_msg       <= '0;
            r_closing   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_cnt   <= '0;
            r_round     <= '0;
            r_word_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (sched_ctl.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (in_acc && i_s_tuser) begin
                r_msg <= r_msg + 61'd1;
            end
            if (in_acc && i_s_tlast) begin
                r_closing <= 1'b1;
            end
            if (r_state == ST_PAD) begin
                if (!r_mark_done) begin
                    r_mark_done <= 1'b1;
                end else if (len_phase) begin
                    r_len_cnt <= r_len_cnt + 4'd1;
                end
            end
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (out_acc) begin
                r_word_idx <= r_word_idx + 2'd1;
                if (r_word_idx == 2'd3) begin
                    r_fill      <= '0;
                    r_msg       <= '0;
                    r_closing   <= 1'b0;
                    r_mark_done <= 1'b0;
                    r_len_cnt   <= '0;
                end
            end
        end
    end

    // digest word select
    assign o_m_tdata = chain[64*(3-r_word_idx) +: 64];
    assign o_m_tuser = r_word_idx;
    assign o_m_tlast = (r_word_idx == 2'd3);

    sha256bs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_word)
    );

    sha256bs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_w     (w_word),
        .o_chain (chain)
    );

endmodule

/* test/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams of the byte stream SHA-256 hasher. Every accepted
// input byte runs through an independent SHA-256 model (block buffer, length
// count, FIPS 180-4 padding), and each closed message queues its four digest
// words. Accepted digest words are compared field by field, oldest first.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // end_of_message
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [63:0] digest_word
    input  logic [1:0]  i_m_tuser,   // [1:0] word_index
    input  logic        i_m_tlast,   // last_word
    output int          o_mismatches,
    output int          o_pending,
    output int          o_words_checked
);

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [63:0] digest;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    // hashing state of the model
    logic [31:0]  chain_h [8];
    logic [7:0]   block_bytes [64];
    logic [6:0]   fill;
    logic [60:0]  msg_len;
    t_digest_word digest_words_due [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // 64 rounds over the buffered block, folded into the chaining value
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        {va, vb, vc, vd} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
        {ve, vf, vg, vh} = {chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = vh + (ror(ve, 6) ^ ror(ve, 11) ^ ror(ve, 25))
                 + ((ve & vf) ^ (~ve & vg)) + ROUND_K[t] + w[t];
            t2 = (ror(va, 2) ^ ror(va, 13) ^ ror(va, 22))
                 + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
        chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        block_bytes[fill[5:0]] = b;
        fill = fill + 7'd1;
        if (fill == 7'd64) begin
            compress_block();
            fill = '0;
        end
    endtask

    // padding, length, then four digest words and a fresh chaining value
    task automatic close_message();
        logic [63:0]  bit_len;
        t_digest_word dw;
        bit_len = {msg_len, 3'b000};
        absorb_byte(8'h80);
        while (fill != 7'd56)
            absorb_byte(8'h00);
        for (int k = 0; k < 8; k++)
            absorb_byte(bit_len[63 - 8*k -: 8]);
        for (int k = 0; k < 4; k++) begin
            dw.digest = {chain_h[2*k], chain_h[2*k+1]};
            dw.index  = k[1:0];
            dw.last   = (k == 3);
            digest_words_due = {digest_words_due, dw};
        end
        chain_h = SHA_IV;
        fill    = '0;
        msg_len = '0;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (o_mismatches < 10)
            $display("digest word %0d: %s expected %h got %h",
                     o_words_checked, what, want, got);
        o_mismatches++;
    endtask

    // both channels sampled at the edge on which the handshake completes
    always @(posedge i_clk) begin
        t_digest_word dw;
        if (!i_rst_n) begin
            chain_h = SHA_IV;
            fill    = '0;
            msg_len = '0;
            digest_words_due.delete();
            o_mismatches    = 0;
            o_words_checked = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (digest_words_due.size() == 0) begin
                    flag_mismatch("unexpected word, none due", '0, i_m_tdata);
                end else begin
                    dw = digest_words_due.pop_front();
                    if (i_m_tdata !== dw.digest)
                        flag_mismatch("digest_word", dw.digest, i_m_tdata);
                    if (i_m_tuser !== dw.index)
                        flag_mismatch("word_index", 64'(dw.index), 64'(i_m_tuser));
                    if (i_m_tlast !== dw.last)
                        flag_mismatch("last_word", 64'(dw.last), 64'(i_m_tlast));
                end
                o_words_checked++;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    absorb_byte(i_s_tdata);
                    msg_len = msg_len + 61'd1;
                end
                if (i_s_tlast)
                    close_message();
            end
        end
        o_pending = digest_words_due.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream SHA-256 hasher test. A short directed set (empty message,
// single extreme bytes, ignored bytes, closing with and without a byte) is
// followed by random messages of mixed length around the padding boundaries,
// under four handshake phases and one long digest back-pressure stretch.
// The checker module predicts and compares every digest word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WORDS_PER_PHASE = 60;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] data_byte
    logic        i_s_tuser;   // [0] byte_valid
    logic        i_s_tlast;   // end_of_message
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // [63:0] digest_word
    logic [1:0]  o_m_tuser;   // [1:0] word_index
    logic        o_m_tlast;   // last_word

    int mismatches, pending, words_checked;
    int idle_pct, stall_pct;
    bit hold_req;
    int words_sent, bytes_sent, ignored_sent, messages_sent;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sha256_byte_stream_hasher_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    sha256_digest_checker digest_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_s_tlast       (i_s_tlast),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tuser       (o_m_tuser),
        .i_m_tlast       (o_m_tlast),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic has_byte, input logic eom);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= has_byte;
        i_s_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (has_byte || eom)
            words_sent++;
        else
            ignored_sent++;
        if (has_byte)
            bytes_sent++;
        if (eom)
            messages_sent++;
    endtask

    // random message, closed either on its last byte or by a bare close
    task automatic send_message(input int len);
        bit close_on_byte;
        int plain;
        close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        plain = close_on_byte ? len - 1 : len;
        for (int i = 0; i < plain; i++) begin
            if ($urandom_range(0, 99) < 8)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), close_on_byte, 1'b1);
    endtask

    // mostly short messages, a good share around the 55/56/64 byte edges
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 8);
        if (r < 75) return $urandom_range(9, 54);
        if (r < 93) return $urandom_range(52, 72);
        return $urandom_range(110, 135);
    endfunction

    // digest receiver, with one long hold-off on request
    initial begin : digest_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_used) begin
                hold_used = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ends the run if neither stream moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int target;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 0;
        words_sent    = 0;
        bytes_sent    = 0;
        ignored_sent  = 0;
        messages_sent = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        i_s_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then single-byte messages at the byte extremes
        send_word(8'h3c, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        // "abc"
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // ignored bytes in the middle, close without a byte
        send_word(8'h5a, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h3c, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // alternating bit patterns, closed on the last byte
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h0f, 1'b1, 1'b0);
        send_word(8'hf0, 1'b1, 1'b1);

        // random messages across the four handshake phases
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_req  = 1;
                end
                1: begin
                    idle_pct  = 81;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 81;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
                send_message(pick_length());
        end
        i_s_tvalid <= 1'b0;

        // let the checker take in the closing word before polling its queue
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d messages: %0d bytes, %0d ignored words, %0d input words",
                 messages_sent, bytes_sent, ignored_sent, words_sent);
        $display("Checked %0d digest words under four handshake phases and one long hold",
                 words_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sha256bs_pkg.sv
hdl/sha256bs_sched.sv
hdl/sha256bs_core.sv
hdl/sha256_byte_stream_hasher_top.sv
test/sha256_digest_checker.sv
test/testbench.sv
